FILE: hdl/mcm_pkg.sv
// ----------------------------------------------------------------------------
// mcm_pkg
// Shared types and codes for the message channel mailbox.
// ----------------------------------------------------------------------------
package mcm_pkg;

  typedef enum logic [2:0] {
    ACT_CREATE  = 3'd0,
    ACT_CONNECT = 3'd1,
    ACT_SEND    = 3'd2,
    ACT_RECV    = 3'd3,
    ACT_CLEANUP = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BADCH    = 3'd1,
    ST_BADLEN   = 3'd2,
    ST_SMALL    = 3'd3,
    ST_FULL     = 3'd4,
    ST_EMPTY    = 3'd5,
    ST_NOTFOUND = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SEND_CHK,
    S_COPY_RD,
    S_COPY_WR,
    S_RECV_LEN,
    S_RECV_CHK,
    S_RECV_RD,
    S_RECV_OUT,
    S_RESULT
  } state_t;

  localparam int KEY_W   = 32;
  localparam int OWNER_W = 16;
  localparam int LEN_W   = 7;
  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 4;

endpackage

FILE: hdl/message_channel_mailbox_top.sv
// ----------------------------------------------------------------------------
// message_channel_mailbox_top
// Channel table with per-channel rings of byte messages.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream (in_*): one transaction per action. tdata carries action,
//    channel_key, channel_index, owner_id, msg_length, data_byte, buf_capacity;
//    tlast carries last_byte.
//  - Output stream (out_*): tdata carries status, slot_index, length_out,
//    byte_out; tlast marks the final result of an action.
//  - The block takes one action at a time; in_tready is low while working.
//  - Create/connect/cleanup walk the channel table one slot per cycle.
//  - Send of a non-last byte stages it. The last byte is checked; when accepted,
//    each byte is copied into the message memory by a read, then a write.
//  - Receive: an error status is returned as one result; otherwise each byte
//    takes a memory read, then the output register, limited by one memory port.
//  - A stalled receiver holds out_tvalid/out_tdata; the sequencer waits.
//  - Reset clears the channel table and staging count; message memories are
//    not cleared (never read before written).
module message_channel_mailbox_top
  import mcm_pkg::*;
#(
  parameter int CHANNELS      = 16,
  parameter int QUEUE_DEPTH   = 8,
  parameter int MAX_MSG_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // action[2:0], channel_key[34:3], channel_index[38:35], owner_id[54:39],
  // msg_length[61:55], data_byte[69:62], buf_capacity[76:70]
  input  logic [79:0] in_tdata,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[2:0], slot_index[6:3], length_out[13:7], byte_out[21:14]
  output logic [23:0] out_tdata,
  output logic        out_tlast
);

  localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int BW  = (MAX_MSG_BYTES > 1) ? $clog2(MAX_MSG_BYTES) : 1;
  localparam int CNW = $clog2(QUEUE_DEPTH + 1);
  localparam int CSW = $clog2(CHANNELS + 1);
  localparam int LD  = CHANNELS * QUEUE_DEPTH;
  localparam int MD  = LD * MAX_MSG_BYTES;
  localparam int LAW = (LD > 1) ? $clog2(LD) : 1;
  localparam int MAW = (MD > 1) ? $clog2(MD) : 1;

  // input fields
  logic [2:0]         f_action;
  logic [KEY_W-1:0]   f_key;
  logic [IDX_W-1:0]   f_idx;
  logic [OWNER_W-1:0] f_owner;
  logic [LEN_W-1:0]   f_mlen;
  logic [BYTE_W-1:0]  f_byte;
  logic [LEN_W-1:0]   f_cap;
  assign f_action = in_tdata[2:0];
  assign f_key    = in_tdata[34:3];
  assign f_idx    = in_tdata[38:35];
  assign f_owner  = in_tdata[54:39];
  assign f_mlen   = in_tdata[61:55];
  assign f_byte   = in_tdata[69:62];
  assign f_cap    = in_tdata[76:70];

  // channel table (flip-flops, reset cleared)
  logic [CHANNELS-1:0] used_r;
  logic [KEY_W-1:0]    key_r   [CHANNELS];
  logic [OWNER_W-1:0]  owner_r [CHANNELS];
  logic [QW-1:0]       head_r  [CHANNELS];
  logic [QW-1:0]       tail_r  [CHANNELS];
  logic [CNW-1:0]      count_r [CHANNELS];

  // memories
  logic [LEN_W-1:0]  len_mem   [LD];
  logic [BYTE_W-1:0] msg_mem   [MD];
  logic [BYTE_W-1:0] stage_mem [MAX_MSG_BYTES];

  logic [LEN_W-1:0] stage_cnt_r;

  // latched action
  logic [2:0]         act_r;
  logic [KEY_W-1:0]   akey_r;
  logic [IDX_W-1:0]   aidx_r;
  logic [OWNER_W-1:0] aown_r;
  logic [LEN_W-1:0]   amlen_r;
  logic [LEN_W-1:0]   acap_r;
  logic [LEN_W-1:0]   nstage_r;

  // sequencer
  state_t         state_r, state_nxt;
  logic [CSW-1:0] scan_r;
  logic [CW-1:0]  free_r;
  logic           free_ok_r;
  logic [LEN_W-1:0] pos_r;
  logic [LEN_W-1:0] rlen_r;
  logic [LAW-1:0]   qa_r;
  logic [BYTE_W-1:0] stage_q_r;
  logic [BYTE_W-1:0] msg_q_r;
  logic [LEN_W-1:0]  len_q_r;

  // pending single result
  logic              res_go_r;
  status_t           res_st_r;
  logic [IDX_W-1:0]  res_slot_r;
  logic [LEN_W-1:0]  res_len_r;
  logic [BYTE_W-1:0] res_byte_r;
  logic              res_last_r;

  // output register
  logic        ov_r;
  logic [23:0] od_r;
  logic        ol_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

  logic           ch_ok;
  logic [CW-1:0]  ch;
  logic [CW-1:0]  sc;
  logic [CW-1:0]  fs;
  logic [LEN_W-1:0] head_len;
  logic           send_ok;
  logic           recv_ok;
  logic           out_load;
  logic [LAW-1:0] qa_nxt;
  logic [MAW-1:0] maddr;

  assign ch_ok = ({{(32-IDX_W){1'b0}}, aidx_r} < 32'(CHANNELS));
  assign ch    = CW'(aidx_r);
  assign sc    = scan_r[CW-1:0];
  assign fs    = free_ok_r ? free_r : sc;
  assign qa_nxt = LAW'(ch) * LAW'(QUEUE_DEPTH);
  assign maddr = MAW'(qa_r) * MAW'(MAX_MSG_BYTES) + MAW'(pos_r);

  // head length, forced to one byte if out of range
  assign head_len = (len_q_r == '0 || 32'(len_q_r) > 32'(MAX_MSG_BYTES)) ? 7'd1 : len_q_r;

  // commit and delivery decisions
  assign send_ok = ch_ok && amlen_r != '0 && 32'(amlen_r) <= 32'(MAX_MSG_BYTES) &&
                   amlen_r == nstage_r && used_r[ch] &&
                   32'(count_r[ch]) < 32'(QUEUE_DEPTH);
  assign recv_ok = ch_ok && used_r[ch] && count_r[ch] != '0 && acap_r >= head_len;

  // output register load
  assign out_load = (state_r == S_RECV_OUT) ||
                    (state_r == S_RESULT && res_go_r && (!ov_r || out_tready));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_tvalid) begin
        if (f_action == ACT_SEND) state_nxt = in_tlast ? S_SEND_CHK : S_RESULT;
        else if (f_action == ACT_RECV) state_nxt = S_RECV_LEN;
        else if (f_action <= ACT_CLEANUP) state_nxt = S_SCAN;
        else state_nxt = S_RESULT;
      end
      S_SCAN:     if (32'(scan_r) >= 32'(CHANNELS - 1)) state_nxt = S_RESULT;
      S_SEND_CHK: state_nxt = send_ok ? S_COPY_RD : S_RESULT;
      S_COPY_RD:  state_nxt = S_COPY_WR;
      S_COPY_WR:  state_nxt = (pos_r + 7'd1 >= amlen_r) ? S_RESULT : S_COPY_RD;
      S_RECV_LEN: state_nxt = S_RECV_CHK;
      S_RECV_CHK: state_nxt = recv_ok ? S_RECV_RD : S_RESULT;
      S_RECV_RD:  if (!ov_r || out_tready) state_nxt = S_RECV_OUT;
      S_RECV_OUT: state_nxt = (pos_r + 7'd1 >= rlen_r) ? S_IDLE : S_RECV_RD;
      S_RESULT:   if (!ov_r || out_tready) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid && f_action == ACT_SEND &&
        32'(stage_cnt_r) < 32'(MAX_MSG_BYTES))
      stage_mem[BW'(stage_cnt_r)] <= f_byte;
    stage_q_r <= stage_mem[BW'(pos_r)];
    if (state_r == S_COPY_WR) msg_mem[maddr] <= stage_q_r;
    msg_q_r <= msg_mem[maddr];
    if (state_r == S_SEND_CHK && send_ok) len_mem[qa_nxt + LAW'(tail_r[ch])] <= amlen_r;
    len_q_r <= len_mem[qa_nxt + LAW'(head_r[ch])];
  end

  // main sequencer datapath; a single compare unit walks the table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r <= '0;
      stage_cnt_r <= '0;
      ov_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        key_r[i] <= '0; owner_r[i] <= '0; head_r[i] <= '0;
        tail_r[i] <= '0; count_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_load) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_tvalid) begin
          act_r <= f_action; akey_r <= f_key; aidx_r <= f_idx;
          aown_r <= f_owner; amlen_r <= f_mlen; acap_r <= f_cap;
          scan_r <= '0; free_ok_r <= 1'b0; free_r <= '0; pos_r <= '0;
          res_st_r <= ST_NOTFOUND; res_slot_r <= '0;
          res_len_r <= '0; res_byte_r <= '0; res_last_r <= 1'b1;
          res_go_r <= (f_action <= ACT_CLEANUP) && !(f_action == ACT_SEND && !in_tlast);
          if (f_action == ACT_SEND) begin
            nstage_r <= (stage_cnt_r < 7'd127) ? stage_cnt_r + 7'd1 : stage_cnt_r;
            if (in_tlast) stage_cnt_r <= '0;
            else if (stage_cnt_r < 7'd127) stage_cnt_r <= stage_cnt_r + 7'd1;
          end
        end
        S_SCAN: begin
          scan_r <= scan_r + CSW'(1);
          if (act_r == ACT_CLEANUP) begin
            res_st_r <= ST_OK;
            if (used_r[sc] && owner_r[sc] == aown_r) begin
              used_r[sc] <= 1'b0; key_r[sc] <= '0; owner_r[sc] <= '0;
              head_r[sc] <= '0; tail_r[sc] <= '0; count_r[sc] <= '0;
            end
          end else if (res_st_r != ST_OK) begin
            if (used_r[sc] && key_r[sc] == akey_r) begin
              res_st_r <= ST_OK; res_slot_r <= IDX_W'(sc);
            end else if (!used_r[sc] && !free_ok_r) begin
              free_ok_r <= 1'b1; free_r <= sc;
            end
          end
          // final step: create claims a free slot on miss, or reports full if none is free
          if (32'(scan_r) >= 32'(CHANNELS - 1) && act_r == ACT_CREATE) begin
            if (res_st_r != ST_OK && !(used_r[sc] && key_r[sc] == akey_r)) begin
              if (free_ok_r || !used_r[sc]) begin
                used_r[fs] <= 1'b1; key_r[fs] <= akey_r; owner_r[fs] <= aown_r;
                head_r[fs] <= '0; tail_r[fs] <= '0; count_r[fs] <= '0;
                res_st_r <= ST_OK; res_slot_r <= IDX_W'(fs);
              end else begin
                res_st_r <= ST_FULL;
              end
            end
          end
        end
        S_SEND_CHK: begin
          res_slot_r <= aidx_r;
          if (!ch_ok) res_st_r <= ST_BADCH;
          else if (amlen_r == '0 || 32'(amlen_r) > 32'(MAX_MSG_BYTES) ||
                   amlen_r != nstage_r) res_st_r <= ST_BADLEN;
          else if (!used_r[ch]) res_st_r <= ST_BADCH;
          else if (32'(count_r[ch]) >= 32'(QUEUE_DEPTH)) res_st_r <= ST_FULL;
          else begin
            res_st_r <= ST_OK; res_len_r <= amlen_r;
            qa_r <= qa_nxt + LAW'(tail_r[ch]);
            tail_r[ch] <= (32'(tail_r[ch]) == QUEUE_DEPTH - 1) ? '0 : tail_r[ch] + QW'(1);
            count_r[ch] <= count_r[ch] + CNW'(1);
          end
        end
        S_COPY_WR: pos_r <= pos_r + 7'd1;
        S_RECV_LEN: begin
          res_slot_r <= aidx_r;
          qa_r <= qa_nxt + LAW'(head_r[ch]);
        end
        S_RECV_CHK: begin
          if (!ch_ok || !used_r[ch]) res_st_r <= ST_BADCH;
          else if (count_r[ch] == '0) res_st_r <= ST_EMPTY;
          else if (acap_r < head_len) begin
            res_st_r <= ST_SMALL; res_len_r <= head_len;
          end else begin
            rlen_r <= head_len;
            head_r[ch] <= (32'(head_r[ch]) == QUEUE_DEPTH - 1) ? '0 : head_r[ch] + QW'(1);
            count_r[ch] <= count_r[ch] - CNW'(1);
          end
        end
        S_RECV_RD: ;
        S_RECV_OUT: begin
          od_r <= {2'b0, msg_q_r, rlen_r, aidx_r, ST_OK};
          ol_r <= (pos_r + 7'd1 >= rlen_r);
          pos_r <= pos_r + 7'd1;
        end
        S_RESULT: if (out_load) begin
          od_r <= {2'b0, res_byte_r, res_len_r, res_slot_r, res_st_r};
          ol_r <= res_last_r;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/mcm_checker.sv
// ----------------------------------------------------------------------------
// mcm_checker
// Port-level checks for the message channel mailbox.
// ----------------------------------------------------------------------------
module mcm_checker
  import mcm_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed under stall");

  // no new input accepted the cycle after one
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("back-to-back accept");

  // status code in range
  a_st: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] != 3'd7)
    else $error("bad status");

  // no output right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output after reset");

endmodule

bind message_channel_mailbox_top mcm_checker u_mcm_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tlast(out_tlast)
);
